>>> rtl/core/tpet_pkg.sv
`timescale 1ns / 1ps

package tpet_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_EVENTS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // Raw time saturates to this signed width on every advance
  localparam int RAW_BITS = 48;

  // Result queue: at most RESULT_CAP fired events per advance
  localparam int RESULT_CAP = 16;
  localparam int HIT_W      = $clog2(RESULT_CAP + 1);
  localparam int QUEUE_AW   = $clog2(RESULT_CAP);
  localparam int EVT_IDX_W  = 4;

  // Stream and configuration port widths
  localparam int IN_DATA_W  = 72;
  localparam int OUT_DATA_W = 40;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP_DURATION = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PLAY_MODE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EVENT_COUNT   = 2'd2;

  // Play modes (code three behaves as loop)
  localparam logic [1:0] MODE_ONCE     = 2'd0;
  localparam logic [1:0] MODE_LOOP     = 2'd1;
  localparam logic [1:0] MODE_PINGPONG = 2'd2;

  // Input opcodes
  localparam logic OP_ADVANCE = 1'b0;
  localparam logic OP_WRITE   = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_BEFORE,
    S_MOD_BEFORE,
    S_SUM,
    S_REDUCE,
    S_MOD_AFTER,
    S_DECIDE,
    S_SCAN_TAIL,
    S_SCAN_LAST,
    S_EMIT
  } tpet_state_t;

  typedef struct packed {
    logic start;
    logic clear;
  } scan_ctl_t;

  typedef struct packed {
    logic             busy;
    logic [HIT_W-1:0] nhit;
  } scan_sts_t;

endpackage

>>> rtl/core/timeline_playback_event_trigger.sv
`timescale 1ns / 1ps

// Channel  Dir  Handshake              Payload
// in_      in   in_tvalid/in_tready    in_tdata: advance, event_slot, event_time; tuser: opcode
// out_     out  out_tvalid/out_tready  out_tdata: playback_time, event_index; tuser, tlast
// cfg_     in   cfg_valid/cfg_ready    cfg_index, cfg_data
//
// An advance runs two passes of the shared one-bit-a-cycle remainder unit, which
// works on the raw-time width (48 by default); clamp mode or a zero duration skips
// them. Table scans follow (two when the range wraps, none when nothing can fire),
// then the result beats, each held while out_tready is low. Reset is synchronous,
// active low; it clears raw time and loads the register defaults.
module timeline_playback_event_trigger #(
  parameter int MAX_EVENTS = tpet_pkg::MAX_EVENTS_DEF,
  parameter int TIME_BITS  = tpet_pkg::TIME_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // input stream
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [31:0] advance, [35:32] event_slot, [67:36] event_time, [71:68] zero
  input  logic [tpet_pkg::IN_DATA_W-1:0]   in_tdata,
  // [0] opcode
  input  logic                             in_tuser,
  // result stream
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [31:0] playback_time, [35:32] event_index, [39:36] zero
  output logic [tpet_pkg::OUT_DATA_W-1:0]  out_tdata,
  // [0] event_valid
  output logic                             out_tuser,
  output logic                             out_tlast,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [tpet_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [tpet_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tpet_pkg::*;

  localparam int TB = TIME_BITS;
  localparam int RW = (TIME_BITS + 2 > RAW_BITS) ? TIME_BITS + 2 : RAW_BITS;
  localparam int CW = TIME_BITS + 1;
  localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int AW = $clog2(MAX_EVENTS + 1);
  localparam int MW = (TIME_BITS > 32) ? TIME_BITS : 32;
  localparam logic signed [RW:0] SAT_HI = {{(RW + 1 - (RAW_BITS - 1)){1'b0}},
                                           {(RAW_BITS - 1){1'b1}}};
  localparam logic signed [RW:0] SAT_LO = {{(RW + 1 - (RAW_BITS - 1)){1'b1}},
                                           {(RAW_BITS - 1){1'b0}}};

  // Configuration registers
  logic [TB-1:0] dur_r;
  logic [1:0]    mode_r;
  logic [4:0]    ecnt_r;

  // Sequencer and datapath registers
  tpet_state_t          state_r, state_nxt;
  logic signed [RW-1:0] raw_r, raw_nxt;
  logic signed [RW-1:0] sum_r, sum_nxt;
  logic signed [31:0]   adv_r, adv_nxt;
  logic [TB-1:0]        before_r, before_nxt;
  logic [TB-1:0]        after_r, after_nxt;
  logic [QUEUE_AW-1:0]  k_r, k_nxt;

  // Helpers
  logic                 mode_once;
  logic                 mode_ping;
  logic                 dur_zero;
  logic [CW-1:0]        cyc;
  logic [CW-1:0]        rem;
  logic                 rem_done;
  logic                 rem_start;
  logic signed [RW-1:0] rem_src;
  logic [TB-1:0]        mod_pos;
  logic [TB-1:0]        clamp_pos;
  logic signed [RW:0]   sum_ext;
  logic signed [RW-1:0] sat_sum;
  logic [31:0]          mag;
  logic [AW-1:0]        ecnt_eff;
  logic [3:0]           in_slot;
  logic                 wr_en;
  logic [IW-1:0]        wr_addr;
  scan_ctl_t            sctl;
  scan_sts_t            ssts;
  logic [TB-1:0]        s_from;
  logic [TB-1:0]        s_to;
  logic [EVT_IDX_W-1:0] q_idx;
  logic                 ev_valid;

  assign mode_once = (mode_r == MODE_ONCE);
  assign mode_ping = (mode_r == MODE_PINGPONG);
  assign dur_zero  = (dur_r == '0);
  assign cyc       = mode_ping ? {dur_r, 1'b0} : {1'b0, dur_r};

  // Shared remainder unit: works on raw time first, then on the new sum
  assign rem_src = (state_r == S_BEFORE) ? raw_r : sum_r;

  tpet_urem #(
    .DW (RW),
    .CW (CW)
  ) u_urem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (rem_src),
    .divisor  (cyc),
    .done     (rem_done),
    .rem      (rem)
  );

  // Ping-pong: mirror the second half of the doubled cycle
  assign mod_pos = (mode_ping && rem > {1'b0, dur_r}) ? TB'(cyc - rem) : TB'(rem);

  // Clamp mode: hold position inside [0, duration]
  always_comb begin
    if (rem_src[RW-1]) begin
      clamp_pos = '0;
    end else if ($unsigned(rem_src) > RW'(dur_r)) begin
      clamp_pos = dur_r;
    end else begin
      clamp_pos = TB'($unsigned(rem_src));
    end
  end

  // Add the step and saturate to the signed raw-time range
  assign sum_ext = $signed({raw_r[RW-1], raw_r}) +
                   $signed({{(RW + 1 - 32){adv_r[31]}}, adv_r});
  always_comb begin
    if (sum_ext > SAT_HI) begin
      sat_sum = RW'(SAT_HI);
    end else if (sum_ext < SAT_LO) begin
      sat_sum = RW'(SAT_LO);
    end else begin
      sat_sum = RW'(sum_ext);
    end
  end

  assign mag      = adv_r[31] ? 32'(-adv_r) : 32'(adv_r);
  assign ecnt_eff = ({27'd0, ecnt_r} > 32'(MAX_EVENTS)) ? AW'(MAX_EVENTS) : AW'(ecnt_r);
  assign in_slot  = in_tdata[35:32];
  assign wr_addr  = IW'(in_slot);

  tpet_scan #(
    .MAX_EVENTS (MAX_EVENTS),
    .TIME_BITS  (TIME_BITS)
  ) u_scan (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_time   (TB'(in_tdata[67:36])),
    .ctl       (sctl),
    .from_time (s_from),
    .to_time   (s_to),
    .count     (ecnt_eff),
    .sts       (ssts),
    .q_addr    (k_r),
    .q_idx     (q_idx)
  );

  // Configuration port: always ready and takes effect at once; write between advances
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dur_r  <= '0;
      mode_r <= MODE_LOOP;
      ecnt_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_CLIP_DURATION: dur_r  <= TB'(cfg_data);
        CFG_PLAY_MODE:     mode_r <= cfg_data[1:0];
        CFG_EVENT_COUNT:   ecnt_r <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // State register and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      raw_r   <= '0;
    end else begin
      state_r <= state_nxt;
      raw_r   <= raw_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sum_r    <= sum_nxt;
    adv_r    <= adv_nxt;
    before_r <= before_nxt;
    after_r  <= after_nxt;
    k_r      <= k_nxt;
  end

  // Sequencer: next state and unit commands
  always_comb begin
    state_nxt  = state_r;
    raw_nxt    = raw_r;
    sum_nxt    = sum_r;
    adv_nxt    = adv_r;
    before_nxt = before_r;
    after_nxt  = after_r;
    k_nxt      = k_r;
    rem_start  = 1'b0;
    wr_en      = 1'b0;
    sctl       = '0;
    s_from     = '0;
    s_to       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          if (in_tuser == OP_WRITE) begin
            // drop writes beyond the table
            wr_en = ({28'd0, in_slot} < 32'(MAX_EVENTS));
          end else begin
            adv_nxt   = $signed(in_tdata[31:0]);
            state_nxt = S_BEFORE;
          end
        end
      end
      S_BEFORE: begin
        if (dur_zero) begin
          before_nxt = '0;
          state_nxt  = S_SUM;
        end else if (mode_once) begin
          before_nxt = clamp_pos;
          state_nxt  = S_SUM;
        end else begin
          rem_start = 1'b1;
          state_nxt = S_MOD_BEFORE;
        end
      end
      S_MOD_BEFORE: begin
        if (rem_done) begin
          before_nxt = mod_pos;
          state_nxt  = S_SUM;
        end
      end
      S_SUM: begin
        sum_nxt   = sat_sum;
        state_nxt = S_REDUCE;
      end
      S_REDUCE: begin
        if (!mode_once && !dur_zero) begin
          rem_start = 1'b1;
          state_nxt = S_MOD_AFTER;
        end else begin
          raw_nxt   = sum_r;
          after_nxt = dur_zero ? '0 : clamp_pos;
          state_nxt = S_DECIDE;
        end
      end
      S_MOD_AFTER: begin
        if (rem_done) begin
          // keep raw time reduced into one cycle
          raw_nxt   = $signed(RW'(rem));
          after_nxt = mod_pos;
          state_nxt = S_DECIDE;
        end
      end
      S_DECIDE: begin
        k_nxt      = '0;
        sctl.clear = 1'b1;
        if (ecnt_eff == '0 || dur_zero || adv_r == '0) begin
          state_nxt = S_EMIT;
        end else if (MW'(mag) >= MW'(dur_r)) begin
          // a full lap or more: every event fires once
          sctl.start = 1'b1;
          s_from     = '0;
          s_to       = dur_r;
          state_nxt  = S_SCAN_LAST;
        end else if (mode_once || after_r >= before_r) begin
          sctl.start = 1'b1;
          s_from     = before_r;
          s_to       = after_r;
          state_nxt  = S_SCAN_LAST;
        end else begin
          // wrapped: tail of the clip first
          sctl.start = 1'b1;
          s_from     = before_r;
          s_to       = dur_r;
          state_nxt  = S_SCAN_TAIL;
        end
      end
      S_SCAN_TAIL: begin
        if (!ssts.busy) begin
          // then the head up to the new position
          sctl.start = 1'b1;
          s_from     = '0;
          s_to       = after_r;
          state_nxt  = S_SCAN_LAST;
        end
      end
      S_SCAN_LAST: begin
        if (!ssts.busy) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_tready) begin
          if (out_tlast) begin
            state_nxt = S_IDLE;
          end else begin
            k_nxt = k_r + QUEUE_AW'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result beats: one per fired event, or a single empty beat
  assign in_tready  = (state_r == S_IDLE);
  assign ev_valid   = (ssts.nhit != '0);
  assign out_tvalid = (state_r == S_EMIT);
  assign out_tuser  = ev_valid;
  assign out_tlast  = ev_valid ? ({1'b0, k_r} == ssts.nhit - HIT_W'(1)) : 1'b1;
  assign out_tdata  = {4'd0, (ev_valid ? q_idx : 4'd0), 32'(after_r)};

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_tready && out_tvalid))
    else $error("input taken while results pending");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && out_tlast) |=> in_tready)
    else $error("block not idle after final beat");

  a_scan_in_scan_states: assert property (@(posedge clk) disable iff (!rst_n)
    ssts.busy |-> (state_r == S_SCAN_TAIL || state_r == S_SCAN_LAST))
    else $error("scan running outside scan states");

  a_rem_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == S_MOD_BEFORE || state_r == S_MOD_AFTER))
    else $error("remainder finished with no one waiting");

  a_hit_cap: assert property (@(posedge clk) disable iff (!rst_n)
    ssts.nhit <= HIT_W'(RESULT_CAP))
    else $error("hit queue overflow");
`endif

endmodule

>>> rtl/core/tpet_urem.sv
`timescale 1ns / 1ps

// Iterative signed-dividend remainder: one restoring step per cycle,
// then a fold step that moves the remainder of a negative dividend into [0, divisor).
module tpet_urem #(
  parameter int DW = 48,
  parameter int CW = 33
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic signed [DW-1:0] dividend,
  input  logic        [CW-1:0] divisor,
  output logic                 done,
  output logic        [CW-1:0] rem
);
  import tpet_pkg::*;

  localparam int CNT_W = $clog2(DW + 1);

  logic [DW-1:0]    mag_r;
  logic [CW-1:0]    rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             run_r;
  logic             fix_r;
  logic             neg_r;
  logic             done_r;
  logic [CW:0]      trial;
  logic [CW:0]      trial_sub;

  assign trial     = {rem_r, mag_r[DW-1]};
  assign trial_sub = (trial >= {1'b0, divisor}) ? trial - {1'b0, divisor} : trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fix_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        fix_r <= 1'b0;
      end else if (run_r) begin
        if (cnt_r == CNT_W'(1)) begin
          run_r <= 1'b0;
          fix_r <= 1'b1;
        end
      end else if (fix_r) begin
        fix_r  <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      neg_r <= dividend[DW-1];
      mag_r <= dividend[DW-1] ? DW'(-dividend) : DW'(dividend);
      rem_r <= '0;
      cnt_r <= CNT_W'(DW);
    end else if (run_r) begin
      rem_r <= CW'(trial_sub);
      mag_r <= {mag_r[DW-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end else if (fix_r) begin
      // truncated remainder of a negative value: move it into range
      if (neg_r && rem_r != '0) begin
        rem_r <= divisor - rem_r;
      end
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

>>> rtl/core/tpet_scan.sv
`timescale 1ns / 1ps

// Event table plus a one-entry-per-cycle interval scan that queues
// the slots of matching events in table order.
module tpet_scan #(
  parameter int MAX_EVENTS = 16,
  parameter int TIME_BITS  = 32
) (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    wr_en,
  input  logic [(MAX_EVENTS > 1 ? $clog2(MAX_EVENTS) : 1)-1:0] wr_addr,
  input  logic [TIME_BITS-1:0]                    wr_time,
  input  tpet_pkg::scan_ctl_t                     ctl,
  input  logic [TIME_BITS-1:0]                    from_time,
  input  logic [TIME_BITS-1:0]                    to_time,
  input  logic [$clog2(MAX_EVENTS + 1)-1:0]       count,
  output tpet_pkg::scan_sts_t                     sts,
  input  logic [tpet_pkg::QUEUE_AW-1:0]           q_addr,
  output logic [tpet_pkg::EVT_IDX_W-1:0]          q_idx
);
  import tpet_pkg::*;

  localparam int IW = (MAX_EVENTS > 1) ? $clog2(MAX_EVENTS) : 1;
  localparam int AW = $clog2(MAX_EVENTS + 1);

  logic [TIME_BITS-1:0] mem [MAX_EVENTS];
  logic [EVT_IDX_W-1:0] queue_r [RESULT_CAP];

  logic [TIME_BITS-1:0] rd_r;
  logic [TIME_BITS-1:0] from_r;
  logic [TIME_BITS-1:0] to_r;
  logic [AW-1:0]        lim_r;
  logic [AW-1:0]        addr_r;
  logic [IW-1:0]        pidx_r;
  logic                 act_r;
  logic                 pv_r;
  logic [HIT_W-1:0]     nhit_r;
  logic                 hit;

  assign hit = pv_r && (rd_r >= from_r) && (rd_r < to_r) &&
               (nhit_r < HIT_W'(RESULT_CAP));

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_time;
    end
    if (act_r) begin
      rd_r <= mem[addr_r[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      from_r <= from_time;
      to_r   <= to_time;
      lim_r  <= count;
    end
    if (act_r) begin
      pidx_r <= addr_r[IW-1:0];
    end
    if (hit) begin
      queue_r[nhit_r[QUEUE_AW-1:0]] <= EVT_IDX_W'(pidx_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      pv_r   <= 1'b0;
      addr_r <= '0;
      nhit_r <= '0;
    end else begin
      pv_r <= act_r;
      if (ctl.start) begin
        act_r  <= 1'b1;
        addr_r <= '0;
      end else if (act_r) begin
        addr_r <= addr_r + AW'(1);
        if (addr_r + AW'(1) == lim_r) begin
          act_r <= 1'b0;
        end
      end
      if (ctl.clear) begin
        nhit_r <= '0;
      end else if (hit) begin
        nhit_r <= nhit_r + HIT_W'(1);
      end
    end
  end

  assign sts.busy = act_r | pv_r;
  assign sts.nhit = nhit_r;
  assign q_idx    = queue_r[q_addr];

endmodule

>>> tb/sv/timeline_playback_event_trigger_tb.sv
`timescale 1ns / 1ps

module timeline_playback_event_trigger_tb;
  import tpet_pkg::*;

  // Mode code three is an alias of loop
  localparam logic [1:0] MODE_LOOP_ALIAS = 2'd3;
  // Signed 48-bit saturation bounds of the raw time
  localparam longint RAW_HI = 64'sd140737488355327;
  localparam longint RAW_LO = -RAW_HI - 1;
  // One advance with a full table scan and every result beat, with margin
  localparam int SETTLE_CYCLES = 200;

  typedef struct packed {
    logic        op;
    logic [31:0] adv;
    logic [3:0]  slot;
    logic [31:0] etime;
  } timeline_cmd_t;

  typedef struct packed {
    logic [31:0] pos;
    logic        fired;
    logic [3:0]  idx;
    logic        last_beat;
  } trigger_beat_t;

  logic                  clk;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tuser;
  logic                  out_tlast;
  logic                  cfg_valid  = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index  = '0;
  logic [CFG_DATA_W-1:0] cfg_data   = '0;

  timeline_playback_event_trigger u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Commands waiting for the driver, and the trigger beats still owed by the block
  timeline_cmd_t cmd_q[$];
  trigger_beat_t trigger_q[$];

  // Shadow of the block: registers, raw time and event table
  longint      clip_len = 0;
  logic [1:0]  mode_m   = MODE_LOOP;
  logic [4:0]  ev_count = '0;
  longint      raw_t    = 0;
  longint      evt_at[MAX_EVENTS_DEF];
  logic [3:0]  fired_idx[$];

  int in_idle_pct  = 0;
  int out_idle_pct = 0;
  bit in_taken     = 1'b0;

  int n_adv      = 0;
  int n_writes   = 0;
  int n_settings = 0;
  int n_beats    = 0;
  int n_fired    = 0;
  int n_errors   = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Hard stop in case the block hangs
  initial begin
    #2_000_000;
    $display("timeline_playback_event_trigger verification failed");
    $finish;
  end

  function automatic longint cycle_len_now();
    return (mode_m == MODE_PINGPONG) ? 2 * clip_len : clip_len;
  endfunction

  // Map a raw time to the playback position under the current registers
  function automatic longint position_at(longint raw);
    longint cyc;
    longint w;
    if (clip_len == 0) return 0;
    if (mode_m == MODE_ONCE) begin
      if (raw < 0) return 0;
      if (raw > clip_len) return clip_len;
      return raw;
    end
    cyc = cycle_len_now();
    w = raw % cyc;
    if (w < 0) w += cyc;
    // Mirror the second half of a ping-pong cycle
    if (mode_m == MODE_PINGPONG && w > clip_len) return cyc - w;
    return w;
  endfunction

  // Append, in table order, every valid slot with a time in [lo, hi)
  function automatic void collect(longint lo, longint hi, int cnt);
    for (int i = 0; i < cnt; i++) begin
      if (evt_at[i] >= lo && evt_at[i] < hi && fired_idx.size() < RESULT_CAP)
        fired_idx = {fired_idx, 4'(i)};
    end
  endfunction

  // Apply one accepted command to the shadow and queue the beats it owes
  function automatic void step_timeline(timeline_cmd_t c);
    longint        adv;
    longint        mag;
    longint        sum;
    longint        cyc;
    longint        pos_b;
    longint        pos_a;
    int            cnt;
    trigger_beat_t b;
    if (c.op == OP_WRITE) begin
      evt_at[c.slot] = c.etime;
      n_writes++;
      return;
    end
    n_adv++;
    if (mode_m == MODE_LOOP_ALIAS) mode_m = MODE_LOOP;
    adv = longint'($signed(c.adv));
    mag = (adv < 0) ? -adv : adv;
    pos_b = position_at(raw_t);
    sum = raw_t + adv;
    if (sum > RAW_HI) sum = RAW_HI;
    if (sum < RAW_LO) sum = RAW_LO;
    // Wrap modes keep the raw time reduced into one cycle
    if (mode_m != MODE_ONCE && clip_len != 0) begin
      cyc = cycle_len_now();
      sum = sum % cyc;
      if (sum < 0) sum += cyc;
    end
    raw_t = sum;
    pos_a = position_at(raw_t);
    cnt = (ev_count > MAX_EVENTS_DEF) ? MAX_EVENTS_DEF : int'(ev_count);
    fired_idx.delete();
    if (cnt != 0 && clip_len != 0 && mag != 0) begin
      if (mag >= clip_len) begin
        // A full lap or more fires every event once
        collect(0, clip_len, cnt);
      end else if (mode_m == MODE_ONCE || pos_a >= pos_b) begin
        collect(pos_b, pos_a, cnt);
      end else begin
        // Wrapped: tail of the clip first, then its head
        collect(pos_b, clip_len, cnt);
        collect(0, pos_a, cnt);
      end
    end
    b.pos = pos_a[31:0];
    if (fired_idx.size() == 0) begin
      b.fired = 1'b0;
      b.idx = '0;
      b.last_beat = 1'b1;
      trigger_q = {trigger_q, b};
    end else begin
      foreach (fired_idx[k]) begin
        b.fired = 1'b1;
        b.idx = fired_idx[k];
        b.last_beat = (k == fired_idx.size() - 1);
        trigger_q = {trigger_q, b};
      end
    end
  endfunction

  // Sample both streams on the rising edge
  always @(posedge clk) begin
    trigger_beat_t exp_b;
    if (rst_n) begin
      // Input side: retire the command the block just took and predict it
      if (in_tvalid && in_tready) begin
        step_timeline(cmd_q.pop_front());
        in_taken = 1'b1;
      end
      // Result side: check against the oldest owed beat
      if (out_tvalid && out_tready) begin
        n_beats++;
        if (trigger_q.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected result beat: pos %0d fired %0b idx %0d last %0b",
                   $time, out_tdata[31:0], out_tuser, out_tdata[35:32], out_tlast);
        end else begin
          exp_b = trigger_q.pop_front();
          if (exp_b.fired) n_fired++;
          if (out_tdata[31:0] !== exp_b.pos || out_tuser !== exp_b.fired ||
              out_tdata[35:32] !== exp_b.idx || out_tlast !== exp_b.last_beat) begin
            n_errors++;
            $display("%0t: mismatch: expected pos %0d fired %0b idx %0d last %0b, %s",
                     $time, exp_b.pos, exp_b.fired, exp_b.idx, exp_b.last_beat,
                     $sformatf("got pos %0d fired %0b idx %0d last %0b",
                               out_tdata[31:0], out_tuser, out_tdata[35:32], out_tlast));
          end
        end
      end
    end
  end

  // Drive on the falling edge: hold a beat until taken, idle at random
  always @(negedge clk) begin
    if (!in_tvalid || in_taken) begin
      if (cmd_q.size() > 0 && $urandom_range(99) >= in_idle_pct) begin
        in_tvalid <= 1'b1;
        in_tuser  <= cmd_q[0].op;
        in_tdata  <= {4'b0, cmd_q[0].etime, cmd_q[0].slot, cmd_q[0].adv};
      end else begin
        in_tvalid <= 1'b0;
      end
    end
    in_taken = 1'b0;
    out_tready <= ($urandom_range(99) >= out_idle_pct);
  end

  // Write one register and mirror it once the block takes it
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_CLIP_DURATION: clip_len = data;
      CFG_PLAY_MODE:     mode_m = data[1:0];
      CFG_EVENT_COUNT:   ev_count = data[4:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic apply_settings(logic [31:0] dur, logic [1:0] mode, logic [4:0] cnt);
    cfg_write(CFG_CLIP_DURATION, dur);
    cfg_write(CFG_PLAY_MODE, {30'b0, mode});
    cfg_write(CFG_EVENT_COUNT, {27'b0, cnt});
    n_settings++;
  endtask

  // Drain everything owed, then give a trailing slot write time to land
  task automatic settle();
    while (cmd_q.size() != 0 || trigger_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Unused fields of each command carry random bits
  task automatic push_advance(logic [31:0] a);
    timeline_cmd_t c;
    c.op = OP_ADVANCE;
    c.adv = a;
    c.slot = 4'($urandom);
    c.etime = $urandom;
    cmd_q = {cmd_q, c};
  endtask

  task automatic push_write(logic [3:0] slot, logic [31:0] t);
    timeline_cmd_t c;
    c.op = OP_WRITE;
    c.adv = $urandom;
    c.slot = slot;
    c.etime = t;
    cmd_q = {cmd_q, c};
  endtask

  // Event times mostly inside the clip, with the edges and stray values mixed in
  function automatic logic [31:0] pick_event_time();
    if (clip_len == 0) return $urandom;
    case ($urandom_range(9))
      0: return $urandom;
      1: return clip_len[31:0];
      2: return '0;
      default: return $urandom_range(32'(clip_len - 1), 0);
    endcase
  endfunction

  // Advances around the clip length, small steps both ways and the extremes
  function automatic logic [31:0] pick_advance();
    longint mag;
    case ($urandom_range(11))
      0: mag = 0;
      1: mag = clip_len;
      2: mag = (clip_len > 0) ? clip_len - 1 : 0;
      3: mag = clip_len + 1;
      4: return 32'h7FFF_FFFF;
      5: return 32'h8000_0000;
      6: return $urandom;
      default: mag = $urandom_range((clip_len > 9) ? 32'(clip_len / 3) : 32'd3, 1);
    endcase
    if (mag > 64'sd2147483647) mag = 64'sd2147483647;
    if ($urandom_range(1)) mag = -mag;
    return mag[31:0];
  endfunction

  initial begin
    logic [31:0] dur;
    logic [1:0]  mode;
    logic [4:0]  cnt;
    in_idle_pct  = 35;
    out_idle_pct = 59;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: zero duration first, then fill every slot before any scan
    apply_settings(32'd0, MODE_LOOP, 5'd0);
    push_advance(32'd0);
    for (int i = 0; i < MAX_EVENTS_DEF - 1; i++) push_write(4'(i), 32'(i * 6));
    push_write(4'd15, 32'hFFFF_FFFF);
    settle();

    // Loop: plain step, wrap, backward step, exact lap, both advance extremes
    apply_settings(32'd100, MODE_LOOP, 5'd16);
    push_advance(32'd10);
    push_advance(32'd95);
    push_advance(-32'sd3);
    push_advance(32'd100);
    push_advance(32'h7FFF_FFFF);
    push_advance(32'h8000_0000);
    settle();

    // Ping-pong: cross the mirror point forward, then step back in the mirrored half
    apply_settings(32'd100, MODE_PINGPONG, 5'd16);
    push_advance(32'd150);
    push_advance(-32'sd30);
    settle();

    // Once: clamp at the end, then below zero
    apply_settings(32'd100, MODE_ONCE, 5'd16);
    push_advance(32'd200);
    push_advance(-32'sd1000);
    settle();

    // Longest clip, mode alias of loop, count beyond the table
    apply_settings(32'hFFFF_FFFF, MODE_LOOP_ALIAS, 5'd31);
    push_advance(32'h7FFF_FFFF);
    push_advance(-32'sd5);
    settle();

    // Random: three idling phases, three register settings each
    for (int ph = 0; ph < 3; ph++) begin
      case (ph)
        0: begin in_idle_pct = 35; out_idle_pct = 59; end
        1: begin in_idle_pct = 59; out_idle_pct = 35; end
        default: begin in_idle_pct = 0; out_idle_pct = 0; end
      endcase
      for (int blk = ph * 3; blk < ph * 3 + 3; blk++) begin
        case (blk)
          0: begin dur = $urandom_range(500, 50); mode = MODE_LOOP; cnt = 5'd16; end
          1: begin
            dur = $urandom_range(500, 50);
            mode = MODE_PINGPONG;
            cnt = 5'($urandom_range(16, 1));
          end
          2: begin dur = $urandom_range(500, 50); mode = MODE_ONCE; cnt = 5'd16; end
          3: begin dur = 32'hFFFF_FFFF; mode = MODE_PINGPONG; cnt = 5'd16; end
          4: begin dur = 32'd1; mode = MODE_LOOP; cnt = 5'd31; end
          5: begin dur = 32'd0; mode = MODE_ONCE; cnt = 5'd8; end
          6: begin
            dur = $urandom_range(100, 10);
            mode = MODE_LOOP_ALIAS;
            cnt = 5'($urandom_range(16, 0));
          end
          7: begin dur = $urandom; mode = MODE_LOOP; cnt = 5'd16; end
          default: begin
            dur = $urandom_range(500, 2);
            mode = 2'($urandom_range(3, 0));
            cnt = 5'($urandom_range(16, 0));
          end
        endcase
        apply_settings(dur, mode, cnt);
        // Mostly advances; rewrite slots now and then to move the events
        repeat (22) begin
          if ($urandom_range(99) < 25) push_write(4'($urandom), pick_event_time());
          else push_advance(pick_advance());
        end
        settle();
      end
    end

    $display("covered %0d advances and %0d slot writes under %0d register settings",
             n_adv, n_writes, n_settings);
    $display("checked %0d result beats, %0d with fired events; %0d mismatches",
             n_beats, n_fired, n_errors);
    if (n_errors == 0 && trigger_q.size() == 0) begin
      $display("timeline_playback_event_trigger verification clean");
    end else begin
      $display("timeline_playback_event_trigger verification failed");
    end
    $finish;
  end

endmodule

>>> timeline_playback_event_trigger.f
rtl/core/tpet_pkg.sv
rtl/core/tpet_urem.sv
rtl/core/tpet_scan.sv
rtl/core/timeline_playback_event_trigger.sv
tb/sv/timeline_playback_event_trigger_tb.sv
